### rtl/sst_pkg.sv
// sst_pkg: shared types, constants and helper functions for the source tokenizer.
// No dependencies; compiled first.
package sst_pkg;

  localparam int KEYWORD_BYTES = 8;
  localparam int KW_BITS       = KEYWORD_BYTES * 8;
  localparam int KW_COUNT      = 24;
  localparam int OFFSET_BITS   = 32;
  localparam int LENGTH_BITS   = 16;
  localparam int LINE_BITS     = 24;
  localparam int TYPE_BITS     = 6;
  localparam int OUT_OFS_BITS  = 32;
  localparam int OUT_LEN_BITS  = 16;
  localparam int FIFO_DEPTH    = 4;
  localparam int PTR_BITS      = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS      = $clog2(FIFO_DEPTH + 1);

  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

  // token codes
  localparam logic [TYPE_BITS-1:0] TOK_UNKNOWN = 6'd0;
  localparam logic [TYPE_BITS-1:0] TOK_IDENT   = 6'd1;
  localparam logic [TYPE_BITS-1:0] TOK_NUMBER  = 6'd2;
  localparam logic [TYPE_BITS-1:0] TOK_STRING  = 6'd3;
  localparam logic [TYPE_BITS-1:0] TOK_LPAREN  = 6'd4;
  localparam logic [TYPE_BITS-1:0] TOK_RPAREN  = 6'd5;
  localparam logic [TYPE_BITS-1:0] TOK_LBRACE  = 6'd6;
  localparam logic [TYPE_BITS-1:0] TOK_RBRACE  = 6'd7;
  localparam logic [TYPE_BITS-1:0] TOK_COMMA   = 6'd8;
  localparam logic [TYPE_BITS-1:0] TOK_DOT     = 6'd9;
  localparam logic [TYPE_BITS-1:0] TOK_MINUS   = 6'd10;
  localparam logic [TYPE_BITS-1:0] TOK_PLUS    = 6'd11;
  localparam logic [TYPE_BITS-1:0] TOK_SEMI    = 6'd12;
  localparam logic [TYPE_BITS-1:0] TOK_SLASH   = 6'd13;
  localparam logic [TYPE_BITS-1:0] TOK_STAR    = 6'd14;
  localparam logic [TYPE_BITS-1:0] TOK_BANG    = 6'd15;
  localparam logic [TYPE_BITS-1:0] TOK_EQUAL   = 6'd16;
  localparam logic [TYPE_BITS-1:0] TOK_GREATER = 6'd17;
  localparam logic [TYPE_BITS-1:0] TOK_LESS    = 6'd18;
  localparam int                   TOK_KEY0    = 19;

  // characters
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BANG    = "!";
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_LPAREN  = "(";
  localparam logic [7:0] CH_RPAREN  = ")";
  localparam logic [7:0] CH_STAR    = "*";
  localparam logic [7:0] CH_PLUS    = "+";
  localparam logic [7:0] CH_COMMA   = ",";
  localparam logic [7:0] CH_MINUS   = "-";
  localparam logic [7:0] CH_DOT     = ".";
  localparam logic [7:0] CH_SLASH   = "/";
  localparam logic [7:0] CH_SEMI    = ";";
  localparam logic [7:0] CH_LESS    = "<";
  localparam logic [7:0] CH_EQUAL   = "=";
  localparam logic [7:0] CH_GREATER = ">";
  localparam logic [7:0] CH_USCORE  = "_";
  localparam logic [7:0] CH_LBRACE  = "{";
  localparam logic [7:0] CH_RBRACE  = "}";

  // keywords, right-aligned and zero padded
  localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
    KW_BITS'("if"),      KW_BITS'("else"),    KW_BITS'("false"),  KW_BITS'("for"),
    KW_BITS'("nil"),     KW_BITS'("or"),      KW_BITS'("print"),  KW_BITS'("input"),
    KW_BITS'("var"),     KW_BITS'("loop"),    KW_BITS'("to"),     KW_BITS'("step"),
    KW_BITS'("break"),   KW_BITS'("continue"), KW_BITS'("down"),  KW_BITS'("compeq"),
    KW_BITS'("compneq"), KW_BITS'("compge"),  KW_BITS'("comple"), KW_BITS'("compg"),
    KW_BITS'("compl"),   KW_BITS'("and"),     KW_BITS'("not"),    KW_BITS'("true")
  };

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_MINUS,
    MODE_SLASH,
    MODE_LINEC,
    MODE_BLOCKC,
    MODE_BLOCKSTAR,
    MODE_IDENT,
    MODE_INT,
    MODE_FRAC,
    MODE_STRING
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } item_t;

  typedef struct packed {
    logic [TYPE_BITS-1:0]    token_type;
    logic [OUT_OFS_BITS-1:0] start_offset;
    logic [OUT_LEN_BITS-1:0] token_length;
    logic [LINE_BITS-1:0]    line_number;
    logic                    last_result;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     word0;
    token_t     word1;
  } push_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic [TYPE_BITS-1:0] punct_type(logic [7:0] c);
    logic [TYPE_BITS-1:0] t;
    unique case (c)
      CH_LPAREN:  t = TOK_LPAREN;
      CH_RPAREN:  t = TOK_RPAREN;
      CH_LBRACE:  t = TOK_LBRACE;
      CH_RBRACE:  t = TOK_RBRACE;
      CH_COMMA:   t = TOK_COMMA;
      CH_DOT:     t = TOK_DOT;
      CH_MINUS:   t = TOK_MINUS;
      CH_PLUS:    t = TOK_PLUS;
      CH_SEMI:    t = TOK_SEMI;
      CH_SLASH:   t = TOK_SLASH;
      CH_STAR:    t = TOK_STAR;
      CH_BANG:    t = TOK_BANG;
      CH_EQUAL:   t = TOK_EQUAL;
      CH_GREATER: t = TOK_GREATER;
      CH_LESS:    t = TOK_LESS;
      default:    t = TOK_UNKNOWN;
    endcase
    return t;
  endfunction

endpackage

### rtl/sst_if.sv
// Valid/ready channel interfaces for source bytes in and token words out.
// Depends on sst_pkg.
interface sst_byte_if;
  import sst_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_input;
  modport source (output valid, output char_byte, output end_of_input, input ready);
  modport sink (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface sst_token_if;
  import sst_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [TYPE_BITS-1:0]    token_type;
  logic [OUT_OFS_BITS-1:0] start_offset;
  logic [OUT_LEN_BITS-1:0] token_length;
  logic [LINE_BITS-1:0]    line_number;
  logic                    last_result;
  modport source (output valid, output token_type, output start_offset, output token_length,
                  output line_number, output last_result, input ready);
  modport sink (input valid, input token_type, input start_offset, input token_length,
                input line_number, input last_result, output ready);
endinterface

### rtl/sst_keyword.sv
// sst_keyword: parallel compare of the identifier window against the keyword list.
// Depends on sst_pkg.
module sst_keyword (
  input  logic [sst_pkg::KW_BITS-1:0]     win_i,
  input  logic [sst_pkg::LENGTH_BITS-1:0] len_i,
  input  logic                            too_long_i,
  output logic [sst_pkg::TYPE_BITS-1:0]   type_o
);
  import sst_pkg::*;

  logic eligible;

  assign eligible = !too_long_i && (len_i <= LENGTH_BITS'(KEYWORD_BYTES));

  always_comb begin
    type_o = TOK_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (eligible && (win_i == KW_TEXT[i])) begin
        type_o = TYPE_BITS'(TOK_KEY0 + i);
      end
    end
  end

endmodule

### rtl/sst_out_fifo.sv
// sst_out_fifo: small token queue, up to two words written and one read per cycle.
// Depends on sst_pkg.
module sst_out_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sst_pkg::push_t push_i,
  output logic           room_o,
  output logic           valid_o,
  input  logic           ready_i,
  output sst_pkg::token_t head_o
);
  import sst_pkg::*;

  token_t               mem [FIFO_DEPTH];
  logic [PTR_BITS-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic                 pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem[rd_q];
  assign room_o  = (cnt_q <= CNT_BITS'(FIFO_DEPTH - 2));

  always_comb begin
    wr_d  = wr_q + PTR_BITS'(push_i.count);
    rd_d  = rd_q + PTR_BITS'(pop);
    cnt_d = cnt_q + CNT_BITS'(push_i.count) - CNT_BITS'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem[wr_q] <= push_i.word0;
    end
    if (push_i.count == 2'd2) begin
      mem[wr_q + 1'b1] <= push_i.word1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_BITS'(FIFO_DEPTH))
    else $error("token queue overfilled");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> (cnt_q <= CNT_BITS'(FIFO_DEPTH - 2)))
    else $error("token push without room");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q == PTR_BITS'(rd_q + PTR_BITS'(cnt_q)))
    else $error("queue pointers out of step with count");

endmodule

### rtl/sst_scan.sv
// sst_scan: scanner state and per-byte step; emits up to two token words per item.
// Depends on sst_pkg and sst_keyword.
module sst_scan (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           go_i,
  input  sst_pkg::item_t item_i,
  output sst_pkg::push_t push_o
);
  import sst_pkg::*;

  scan_mode_e             mode_q, mode_d;
  logic [KW_BITS-1:0]     win_q, win_d;
  logic                   too_long_q, too_long_d;
  logic [OFFSET_BITS-1:0] begin_q, begin_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic                   done_q, done_d;

  logic [7:0]             c;
  logic                   eoi, live, restart;
  logic                   c_digit, c_alpha, c_word, c_other;
  logic [LINE_BITS-1:0]   line_inc;
  logic [LENGTH_BITS-1:0] len_sat;
  logic [TYPE_BITS-1:0]   ident_type;
  logic                   a_v, b_v;
  token_t                 a_rec, b_rec;

  function automatic token_t make_rec(logic [TYPE_BITS-1:0] t, logic [OFFSET_BITS-1:0] b,
                                      logic [LENGTH_BITS-1:0] l, logic [LINE_BITS-1:0] ln);
    token_t r;
    r.token_type   = t;
    r.start_offset = OUT_OFS_BITS'(b);
    r.token_length = OUT_LEN_BITS'(l);
    r.line_number  = ln;
    r.last_result  = 1'b0;
    return r;
  endfunction

  assign c        = item_i.char_byte;
  assign eoi      = item_i.end_of_input;
  assign live     = go_i && !done_q;
  assign c_digit  = is_digit(c);
  assign c_alpha  = is_alpha(c);
  assign c_word   = c_digit || c_alpha || (c == CH_USCORE);
  assign c_other  = !(c == CH_SPACE || c == CH_CR || c == CH_TAB || c == CH_NL ||
                      c == CH_SLASH || c == CH_MINUS || c == CH_QUOTE || c_alpha || c_digit);
  assign line_inc = (line_q == LINE_MAX) ? line_q : line_q + 1'b1;
  assign len_sat  = (len_q == '1) ? len_q : len_q + 1'b1;

  sst_keyword u_keyword (
    .win_i      (win_q),
    .len_i      (len_q),
    .too_long_i (too_long_q),
    .type_o     (ident_type)
  );

  // current token ends on this byte and the byte starts over from idle
  always_comb begin
    unique case (mode_q)
      MODE_IDLE:  restart = 1'b1;
      MODE_MINUS: restart = !c_digit;
      MODE_SLASH: restart = !(c == CH_SLASH || c == CH_STAR);
      MODE_IDENT: restart = !c_word;
      MODE_INT:   restart = !(c_digit || c == CH_DOT);
      MODE_FRAC:  restart = !c_digit;
      default:    restart = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    mode_d     = mode_q;
    win_d      = win_q;
    too_long_d = too_long_q;
    begin_d    = begin_q;
    len_d      = len_q;
    pos_d      = pos_q;
    line_d     = line_q;
    done_d     = done_q;
    if (live) begin
      if (eoi) begin
        mode_d = MODE_IDLE;
        done_d = 1'b1;
      end else begin
        pos_d = pos_q + 1'b1;
        unique case (mode_q)
          MODE_MINUS: begin
            if (c_digit) begin
              mode_d = MODE_INT;
              len_d  = LENGTH_BITS'(2);
            end
          end
          MODE_SLASH: begin
            if (c == CH_SLASH) mode_d = MODE_LINEC;
            else if (c == CH_STAR) mode_d = MODE_BLOCKC;
          end
          MODE_LINEC: begin
            if (c == CH_NL) begin
              line_d = line_inc;
              mode_d = MODE_IDLE;
            end
          end
          MODE_BLOCKC: begin
            if (c == CH_STAR) mode_d = MODE_BLOCKSTAR;
            else if (c == CH_NL) line_d = line_inc;
          end
          MODE_BLOCKSTAR: begin
            if (c == CH_SLASH) begin
              mode_d = MODE_IDLE;
            end else if (c != CH_STAR) begin
              if (c == CH_NL) line_d = line_inc;
              mode_d = MODE_BLOCKC;
            end
          end
          MODE_IDENT: begin
            if (c_word) begin
              if (!too_long_q && (len_q < LENGTH_BITS'(KEYWORD_BYTES))) begin
                win_d = {win_q[KW_BITS-9:0], c};
              end else begin
                too_long_d = 1'b1;
              end
              len_d = len_sat;
            end
          end
          MODE_INT: begin
            if (c_digit) begin
              len_d = len_sat;
            end else if (c == CH_DOT) begin
              len_d  = len_sat;
              mode_d = MODE_FRAC;
            end
          end
          MODE_FRAC: begin
            if (c_digit) len_d = len_sat;
          end
          MODE_STRING: begin
            if (c == CH_QUOTE) mode_d = MODE_IDLE;
            else len_d = len_sat;
          end
          default: ;
        endcase
        if (restart) begin
          mode_d  = MODE_IDLE;
          begin_d = pos_q;
          if (c == CH_NL) begin
            line_d = line_inc;
          end else if (c == CH_SLASH) begin
            mode_d = MODE_SLASH;
          end else if (c == CH_MINUS) begin
            mode_d = MODE_MINUS;
          end else if (c_alpha) begin
            mode_d     = MODE_IDENT;
            win_d      = KW_BITS'(c);
            too_long_d = 1'b0;
            len_d      = LENGTH_BITS'(1);
          end else if (c_digit) begin
            mode_d = MODE_INT;
            len_d  = LENGTH_BITS'(1);
          end else if (c == CH_QUOTE) begin
            mode_d  = MODE_STRING;
            begin_d = pos_q + 1'b1;
            len_d   = '0;
          end
        end
      end
    end
  end

  // token words
  always_comb begin
    a_v   = 1'b0;
    b_v   = 1'b0;
    a_rec = make_rec(TOK_UNKNOWN, begin_q, len_q, line_q);
    b_rec = make_rec(TOK_UNKNOWN, pos_q, '0, line_q);
    if (live) begin
      if (eoi) begin
        b_v = 1'b1;
        unique case (mode_q)
          MODE_MINUS: begin
            a_v   = 1'b1;
            a_rec = make_rec(TOK_MINUS, begin_q, LENGTH_BITS'(1), line_q);
          end
          MODE_SLASH: begin
            a_v   = 1'b1;
            a_rec = make_rec(TOK_SLASH, begin_q, LENGTH_BITS'(1), line_q);
          end
          MODE_IDENT: begin
            a_v   = 1'b1;
            a_rec = make_rec(ident_type, begin_q, len_q, line_q);
          end
          MODE_INT, MODE_FRAC: begin
            a_v   = 1'b1;
            a_rec = make_rec(TOK_NUMBER, begin_q, len_q, line_q);
          end
          MODE_STRING: begin
            a_v   = 1'b1;
            a_rec = make_rec(TOK_STRING, begin_q, len_q, line_q);
          end
          default: ;
        endcase
      end else begin
        unique case (mode_q)
          MODE_MINUS: begin
            a_v   = restart;
            a_rec = make_rec(TOK_MINUS, begin_q, LENGTH_BITS'(1), line_q);
          end
          MODE_SLASH: begin
            a_v   = restart;
            a_rec = make_rec(TOK_SLASH, begin_q, LENGTH_BITS'(1), line_q);
          end
          MODE_IDENT: begin
            a_v   = restart;
            a_rec = make_rec(ident_type, begin_q, len_q, line_q);
          end
          MODE_INT, MODE_FRAC: begin
            a_v   = restart;
            a_rec = make_rec(TOK_NUMBER, begin_q, len_q, line_q);
          end
          MODE_STRING: begin
            a_v   = (c == CH_QUOTE);
            a_rec = make_rec(TOK_STRING, begin_q, len_q, line_q);
          end
          default: ;
        endcase
        b_v   = restart && c_other;
        b_rec = make_rec(punct_type(c), pos_q, LENGTH_BITS'(1), line_q);
      end
    end
  end

  always_comb begin
    push_o.count             = {a_v && b_v, a_v ^ b_v};
    push_o.word0             = a_v ? a_rec : b_rec;
    push_o.word0.last_result = !(a_v && b_v);
    push_o.word1             = b_rec;
    push_o.word1.last_result = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      win_q      <= '0;
      too_long_q <= 1'b0;
      begin_q    <= '0;
      len_q      <= '0;
      pos_q      <= '0;
      line_q     <= LINE_BITS'(1);
      done_q     <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      win_q      <= win_d;
      too_long_q <= too_long_d;
      begin_q    <= begin_d;
      len_q      <= len_d;
      pos_q      <= pos_d;
      line_q     <= line_d;
      done_q     <= done_d;
    end
  end

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> done_q)
    else $error("finished flag dropped before reset");

  a_two_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd2) |-> (eoi || restart))
    else $error("two tokens from a byte that does not end a token");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0)
    else $error("line counter at zero");

endmodule

### rtl/script_source_tokenizer.sv
// script_source_tokenizer: top level; input word register, scanner, token queue.
// Depends on sst_pkg, sst_if, sst_scan, sst_keyword, sst_out_fifo.
// Path: an accepted word is held in the input word register, scanned from there once the
// queue has room, and its tokens are written into the token queue that offers them.
// Throughput: one word per cycle while the four-entry queue holds at most two tokens;
// tokens leave one per cycle, so two-token words or a stalled sink hold the input back.
// Reset: asynchronous, clears all scanner state (line counter to one), no clearing pass.
module script_source_tokenizer (
  input logic         clk_i,
  input logic         rst_ni,
  sst_byte_if.sink    byte_i,
  sst_token_if.source token_o
);
  import sst_pkg::*;

  item_t  item_q;
  logic   item_v_q;
  logic   room, step_go;
  push_t  push;
  token_t head;

  assign step_go      = item_v_q && room;
  assign byte_i.ready = !item_v_q || step_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
    end else if (byte_i.ready) begin
      item_v_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      item_q.char_byte    <= byte_i.char_byte;
      item_q.end_of_input <= byte_i.end_of_input;
    end
  end

  sst_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (step_go),
    .item_i (item_q),
    .push_o (push)
  );

  sst_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (token_o.valid),
    .ready_i (token_o.ready),
    .head_o  (head)
  );

  assign token_o.token_type   = head.token_type;
  assign token_o.start_offset = head.start_offset;
  assign token_o.token_length = head.token_length;
  assign token_o.line_number  = head.line_number;
  assign token_o.last_result  = head.last_result;

endmodule

### tb/tb_script_source_tokenizer.sv
// Self-checking testbench for script_source_tokenizer: drives a byte stream through the
// valid/ready input channel and checks every token word against an in-bench predictor.
// Depends on sst_pkg, sst_if and the script_source_tokenizer RTL.
`timescale 1ns / 100ps

module tb_script_source_tokenizer;
  import sst_pkg::*;

  localparam int RANDOM_BYTES = 1050;
  localparam int PHASE1_END   = 360;
  localparam int PHASE2_END   = 720;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int TAIL_CYCLES  = 20;

  logic clk_i = 1'b0;
  logic rst_ni;

  sst_byte_if  byte_if ();
  sst_token_if tok_if ();

  script_source_tokenizer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_if),
    .token_o (tok_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  string kw_names [24] = '{
    "if", "else", "false", "for", "nil", "or", "print", "input", "var", "loop", "to",
    "step", "break", "continue", "down", "compeq", "compneq", "compge", "comple",
    "compg", "compl", "and", "not", "true"
  };
  string      punct_set = "(){},.-+;/*!=><";
  logic [7:0] ws_set [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_NL};

  item_t  bytes_pending [$];
  token_t tokens_due [$];
  token_t fresh_tokens [$];
  token_t got_tok;
  token_t want_tok;
  item_t  next_word;

  int loaded         = 0;
  int tokens_seen    = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  // predictor state
  scan_mode_e              mode_q     = MODE_IDLE;
  logic [7:0]              ident_head [KEYWORD_BYTES] = '{default: 8'h00};
  logic                    too_long   = 1'b0;
  logic [OUT_OFS_BITS-1:0] tok_begin  = '0;
  logic [OUT_LEN_BITS-1:0] tok_len    = '0;
  logic [OUT_OFS_BITS-1:0] byte_pos   = '0;
  logic [LINE_BITS-1:0]    line_no    = 1;
  logic                    done_flag  = 1'b0;

  function automatic logic is_num_char(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void bump_line();
    if (line_no != LINE_MAX) line_no++;
  endfunction

  function automatic void bump_len();
    if (tok_len != '1) tok_len++;
  endfunction

  function automatic void add_token(logic [TYPE_BITS-1:0] kind, logic [OUT_OFS_BITS-1:0] at,
                                    logic [OUT_LEN_BITS-1:0] len);
    token_t t;
    t.token_type   = kind;
    t.start_offset = at;
    t.token_length = len;
    t.line_number  = line_no;
    t.last_result  = 1'b0;
    fresh_tokens = {fresh_tokens, t};
  endfunction

  function automatic logic [TYPE_BITS-1:0] ident_kind();
    logic hit;
    if (too_long || tok_len > OUT_LEN_BITS'(KEYWORD_BYTES)) return TOK_IDENT;
    foreach (kw_names[i]) begin
      if (kw_names[i].len() == int'(tok_len)) begin
        hit = 1'b1;
        for (int j = 0; j < kw_names[i].len(); j++) begin
          if (kw_names[i][j] != ident_head[j]) hit = 1'b0;
        end
        if (hit) return TYPE_BITS'(TOK_KEY0 + i);
      end
    end
    return TOK_IDENT;
  endfunction

  function automatic logic [TYPE_BITS-1:0] punct_kind(logic [7:0] c);
    for (int i = 0; i < punct_set.len(); i++) begin
      if (punct_set[i] == c) return TYPE_BITS'(TOK_LPAREN + i);
    end
    return TOK_UNKNOWN;
  endfunction

  task automatic predict_tokens(logic [7:0] c, logic eoi);
    logic [OUT_OFS_BITS-1:0] pos;
    logic                    again;
    token_t                  t;
    pos   = byte_pos;
    again = 1'b0;
    fresh_tokens.delete();
    if (done_flag) return;
    if (eoi) begin
      case (mode_q)
        MODE_MINUS:           add_token(TOK_MINUS, tok_begin, 1);
        MODE_SLASH:           add_token(TOK_SLASH, tok_begin, 1);
        MODE_IDENT:           add_token(ident_kind(), tok_begin, tok_len);
        MODE_INT, MODE_FRAC:  add_token(TOK_NUMBER, tok_begin, tok_len);
        MODE_STRING:          add_token(TOK_STRING, tok_begin, tok_len);
        default: ;
      endcase
      mode_q = MODE_IDLE;
      add_token(TOK_UNKNOWN, byte_pos, 0);
      done_flag = 1'b1;
    end else begin
      case (mode_q)
        MODE_MINUS: begin
          if (is_num_char(c)) begin
            mode_q  = MODE_INT;
            tok_len = 2;
          end else begin
            add_token(TOK_MINUS, tok_begin, 1);
            again = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) mode_q = MODE_LINEC;
          else if (c == CH_STAR) mode_q = MODE_BLOCKC;
          else begin
            add_token(TOK_SLASH, tok_begin, 1);
            again = 1'b1;
          end
        end
        MODE_LINEC: begin
          if (c == CH_NL) begin
            bump_line();
            mode_q = MODE_IDLE;
          end
        end
        MODE_BLOCKC: begin
          if (c == CH_STAR) mode_q = MODE_BLOCKSTAR;
          else if (c == CH_NL) bump_line();
        end
        MODE_BLOCKSTAR: begin
          if (c == CH_SLASH) mode_q = MODE_IDLE;
          else if (c != CH_STAR) begin
            if (c == CH_NL) bump_line();
            mode_q = MODE_BLOCKC;
          end
        end
        MODE_IDENT: begin
          if (is_letter(c) || is_num_char(c) || c == CH_USCORE) begin
            if (!too_long && tok_len < OUT_LEN_BITS'(KEYWORD_BYTES)) ident_head[tok_len] = c;
            else too_long = 1'b1;
            bump_len();
          end else begin
            add_token(ident_kind(), tok_begin, tok_len);
            again = 1'b1;
          end
        end
        MODE_INT: begin
          if (is_num_char(c)) bump_len();
          else if (c == CH_DOT) begin
            bump_len();
            mode_q = MODE_FRAC;
          end else begin
            add_token(TOK_NUMBER, tok_begin, tok_len);
            again = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (is_num_char(c)) bump_len();
          else begin
            add_token(TOK_NUMBER, tok_begin, tok_len);
            again = 1'b1;
          end
        end
        MODE_STRING: begin
          if (c == CH_QUOTE) begin
            add_token(TOK_STRING, tok_begin, tok_len);
            mode_q = MODE_IDLE;
          end else bump_len();
        end
        default: again = 1'b1;
      endcase
      if (again) begin
        mode_q    = MODE_IDLE;
        tok_begin = pos;
        if (c == CH_SPACE || c == CH_CR || c == CH_TAB) begin
        end else if (c == CH_NL) bump_line();
        else if (c == CH_SLASH) mode_q = MODE_SLASH;
        else if (c == CH_MINUS) mode_q = MODE_MINUS;
        else if (is_letter(c)) begin
          mode_q        = MODE_IDENT;
          ident_head    = '{default: 8'h00};
          ident_head[0] = c;
          too_long      = 1'b0;
          tok_len       = 1;
        end else if (is_num_char(c)) begin
          mode_q  = MODE_INT;
          tok_len = 1;
        end else if (c == CH_QUOTE) begin
          mode_q    = MODE_STRING;
          tok_begin = pos + 1;
          tok_len   = 0;
        end else add_token(punct_kind(c), pos, 1);
      end
      byte_pos = pos + 1;
    end
    foreach (fresh_tokens[i]) begin
      t             = fresh_tokens[i];
      t.last_result = (i == fresh_tokens.size() - 1);
      tokens_due    = {tokens_due, t};
    end
  endtask

  function automatic int sender_idle_pct();
    if (loaded < PHASE1_END) return 22;
    if (loaded < PHASE2_END) return 83;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (loaded < PHASE1_END) return 83;
    if (loaded < PHASE2_END) return 22;
    return 0;
  endfunction

  task automatic log_mismatch(string msg);
    $display("token %0d: %s", tokens_seen, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) log_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  function automatic void push_byte(logic [7:0] c);
    item_t w;
    w.char_byte    = c;
    w.end_of_input = 1'b0;
    bytes_pending  = {bytes_pending, w};
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick_letter();
    logic [7:0] c;
    c = 8'($urandom_range(25));
    return ($urandom_range(1) != 0) ? "a" + c : "A" + c;
  endfunction

  function automatic logic [7:0] ident_char();
    int r;
    r = $urandom_range(63);
    if (r < 52) return pick_letter();
    if (r < 62) return "0" + 8'($urandom_range(9));
    return CH_USCORE;
  endfunction

  function automatic logic [7:0] string_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CH_QUOTE);
    return c;
  endfunction

  // input side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_if.valid        <= 1'b0;
      byte_if.char_byte    <= '0;
      byte_if.end_of_input <= 1'b0;
    end else begin
      if (byte_if.valid && byte_if.ready) predict_tokens(byte_if.char_byte, byte_if.end_of_input);
      if (!byte_if.valid || byte_if.ready) begin
        // hold-off points: let every due token drain first
        if (bytes_pending.size() != 0 &&
            !((loaded == 150 || loaded == 520 || loaded == 900) && tokens_due.size() != 0) &&
            $urandom_range(99) >= sender_idle_pct()) begin
          next_word = bytes_pending.pop_front();
          byte_if.valid        <= 1'b1;
          byte_if.char_byte    <= next_word.char_byte;
          byte_if.end_of_input <= next_word.end_of_input;
          loaded++;
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_if.ready <= 1'b0;
    end else begin
      tok_if.ready <= ($urandom_range(99) >= receiver_idle_pct());
      if (tok_if.valid && tok_if.ready) begin
        got_tok.token_type   = tok_if.token_type;
        got_tok.start_offset = tok_if.start_offset;
        got_tok.token_length = tok_if.token_length;
        got_tok.line_number  = tok_if.line_number;
        got_tok.last_result  = tok_if.last_result;
        if (tokens_due.size() == 0) begin
          log_mismatch($sformatf("unexpected word, type %0d offset %0h",
                                 got_tok.token_type, got_tok.start_offset));
        end else begin
          want_tok = tokens_due.pop_front();
          check_field("token_type", got_tok.token_type, want_tok.token_type);
          check_field("start_offset", got_tok.start_offset, want_tok.start_offset);
          check_field("token_length", got_tok.token_length, want_tok.token_length);
          check_field("line_number", got_tok.line_number, want_tok.line_number);
          check_field("last_result", got_tok.last_result, want_tok.last_result);
        end
        tokens_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int    pick;
    int    n;
    int    start;
    int    kw_turn;
    int    punct_turn;
    item_t w;
    rst_ni               = 1'b0;
    kw_turn              = 0;
    punct_turn           = 0;

    // directed: signed fraction, ident with underscore, both comment styles,
    // newline inside a string, punctuator, byte extremes, tab and CR
    push_text("-7.5 a_9//c\n/**/\"s\n\"!");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h80);
    push_byte(CH_TAB);
    push_byte(CH_CR);

    start = bytes_pending.size();
    while (bytes_pending.size() < start + RANDOM_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 18) begin
        push_text(kw_names[kw_turn % 24]);
        kw_turn++;
        if ($urandom_range(3) == 0) push_byte(ident_char());
      end else if (pick < 28) begin
        push_byte(pick_letter());
        n = $urandom_range(11);
        for (int k = 0; k < n; k++) push_byte(ident_char());
      end else if (pick < 40) begin
        if ($urandom_range(2) == 0) push_byte(CH_MINUS);
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++) push_byte("0" + 8'($urandom_range(9)));
        if ($urandom_range(4) < 2) begin
          push_byte(CH_DOT);
          n = $urandom_range(3);
          for (int k = 0; k < n; k++) push_byte("0" + 8'($urandom_range(9)));
        end
      end else if (pick < 48) begin
        push_byte(CH_QUOTE);
        n = $urandom_range(8);
        for (int k = 0; k < n; k++) push_byte(($urandom_range(5) == 0) ? CH_NL : string_byte());
        push_byte(CH_QUOTE);
      end else if (pick < 52) begin
        push_text("//");
        n = $urandom_range(6);
        for (int k = 0; k < n; k++) push_byte(($urandom_range(1) != 0) ? 8'h61 : 8'h7E);
        push_byte(CH_NL);
      end else if (pick < 56) begin
        push_text("/*");
        n = $urandom_range(8);
        for (int k = 0; k < n; k++) begin
          case ($urandom_range(3))
            0:       push_byte(CH_STAR);
            1:       push_byte(CH_NL);
            default: push_byte(8'($urandom_range(255)));
          endcase
        end
        push_text("*/");
      end else if (pick < 70) begin
        push_byte(punct_set[punct_turn % 15]);
        punct_turn++;
      end else if (pick < 80) begin
        push_byte(ws_set[$urandom_range(3)]);
      end else if (pick < 88) begin
        push_byte(($urandom_range(1) != 0) ? CH_MINUS : CH_SLASH);
        push_byte(8'($urandom_range(255)));
      end else begin
        push_byte(8'($urandom_range(255)));
      end
      if (pick < 40 && $urandom_range(1) != 0) push_byte(ws_set[$urandom_range(3)]);
    end

    // token left open at the end marker
    case ($urandom_range(6))
      0:       push_text("\"open");
      1:       push_text("/* open");
      2:       push_byte(CH_MINUS);
      3:       push_byte(CH_SLASH);
      4:       push_text("print");
      5:       push_text("12.");
      default: ;
    endcase
    w.char_byte    = 8'($urandom_range(255));
    w.end_of_input = 1'b1;
    bytes_pending  = {bytes_pending, w};
    // ignored after the end token
    for (int k = 0; k < 4; k++) begin
      w.char_byte    = 8'($urandom_range(255));
      w.end_of_input = 1'($urandom_range(1));
      bytes_pending  = {bytes_pending, w};
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (bytes_pending.size() == 0);
    @(posedge clk_i);
    while (byte_if.valid) @(posedge clk_i);
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
